// ===== src/psct_pkg.sv =====
package psct_pkg;

	// shapes the register map has room for
	localparam int unsigned NUM_SLOTS = 4;
	localparam int unsigned MAX_SHAPES_DEF = 4;

	// register stages from the accept to the result register
	localparam int unsigned PIPE_DEPTH = 4;

	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W = 64;
	localparam int unsigned SLOT_W = 2;

	// low bit of the register index picks geometry or mode
	localparam logic CFG_SEL_GEOM = 1'b0;
	localparam logic CFG_SEL_MODE = 1'b1;

	localparam int unsigned COORD_W = 16;
	localparam int unsigned ABS_W = 16;           // |p - c| never exceeds 65535
	localparam int unsigned SQ_W = 2 * ABS_W;
	localparam int unsigned RMAG_W = 15;          // positive radius
	localparam int unsigned R2_W = 2 * RMAG_W;
	localparam int unsigned SUM_W = SQ_W + 2;     // three squares

	typedef enum logic [1:0] {
		AXIS_X    = 2'd0,
		AXIS_Y    = 2'd1,
		AXIS_Z    = 2'd2,
		AXIS_NONE = 2'd3
	} axis_t;

	typedef struct packed {
		axis_t axis;
		logic  cyl;
		logic  incl;
		logic  en;
	} mode_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] cz;
		logic signed [COORD_W-1:0] cy;
		logic signed [COORD_W-1:0] cx;
		logic signed [COORD_W-1:0] radius;
	} geom_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic signed [COORD_W-1:0] point_z;
	} point_t;

	typedef struct packed {
		logic clipped;
		logic include_hit;
		logic exclude_hit;
	} res_t;

	// per-stage load enables
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} adv_t;

endpackage

// ===== src/psct_cfg.sv =====
module psct_cfg import psct_pkg::*; #(
	parameter int unsigned NSHAPES = MAX_SHAPES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output geom_t                  geom[NSHAPES],
	output mode_t                  mode[NSHAPES]
);

	logic [SLOT_W-1:0] slot;
	logic              sel;

	assign slot = cfg_index[CFG_INDEX_W-1:1];
	assign sel  = cfg_index[0];

	// slots past NSHAPES are never tested, so their writes are dropped
	for (genvar k = 0; k < NSHAPES; k++) begin : g_slot
		geom_t geom_q;
		mode_t mode_q;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				geom_q <= '0;
				mode_q <= '0;
			end else if (cfg_we && slot == SLOT_W'(k)) begin
				if (sel == CFG_SEL_MODE) begin
					mode_q <= mode_t'(cfg_data[$bits(mode_t)-1:0]);
				end else begin
					geom_q <= geom_t'(cfg_data);
				end
			end
		end

		assign geom[k] = geom_q;
		assign mode[k] = mode_q;
	end

endmodule

// ===== src/psct_shape.sv =====
module psct_shape import psct_pkg::*; (
	input  logic   clk,
	input  adv_t   adv,
	input  point_t pt,
	input  geom_t  geom,
	input  mode_t  mode,
	output logic   inc_hit_s3,
	output logic   exc_hit_s3
);

	function automatic logic [ABS_W-1:0] abs_diff(logic signed [COORD_W-1:0] a,
			logic signed [COORD_W-1:0] b);
		logic signed [COORD_W:0] d;
		d = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
		abs_diff = d[COORD_W] ? ABS_W'(-d) : ABS_W'(d);
	endfunction

	// s1: distances along each axis
	logic [ABS_W-1:0] ax_s1, ay_s1, az_s1;
	// s2: squares
	logic [SQ_W-1:0]  sx_s2, sy_s2, sz_s2;
	logic [R2_W-1:0]  r2_s2;
	logic             rpos_s2;

	logic [RMAG_W-1:0] rmag;
	logic              rpos;
	logic              use_x, use_y, use_z, axis_ok;
	logic [SUM_W-1:0]  sum;
	logic              in_shape;

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			ax_s1 <= abs_diff(pt.point_x, geom.cx);
			ay_s1 <= abs_diff(pt.point_y, geom.cy);
			az_s1 <= abs_diff(pt.point_z, geom.cz);
		end
	end

	assign rpos = !geom.radius[COORD_W-1] && (geom.radius != '0);
	assign rmag = geom.radius[RMAG_W-1:0];

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			sx_s2   <= ax_s1 * ax_s1;
			sy_s2   <= ay_s1 * ay_s1;
			sz_s2   <= az_s1 * az_s1;
			r2_s2   <= rmag * rmag;
			rpos_s2 <= rpos;
		end
	end

	// a cylinder drops the term along its axis; one with no axis never hits
	always_comb begin
		use_x   = 1'b1;
		use_y   = 1'b1;
		use_z   = 1'b1;
		axis_ok = 1'b1;
		if (mode.cyl) begin
			unique case (mode.axis)
				AXIS_X:    use_x = 1'b0;
				AXIS_Y:    use_y = 1'b0;
				AXIS_Z:    use_z = 1'b0;
				AXIS_NONE: axis_ok = 1'b0;
				default:   axis_ok = 1'b0;
			endcase
		end
	end

	assign sum = (use_x ? SUM_W'(sx_s2) : '0)
	           + (use_y ? SUM_W'(sy_s2) : '0)
	           + (use_z ? SUM_W'(sz_s2) : '0);

	assign in_shape = mode.en && rpos_s2 && axis_ok && (sum < SUM_W'(r2_s2));

	always_ff @(posedge clk) begin
		if (adv.s3) begin
			inc_hit_s3 <= in_shape && mode.incl;
			exc_hit_s3 <= in_shape && !mode.incl;
		end
	end

endmodule

// ===== src/point_shape_clip_test_top.sv =====
// Point clip test against up to MAX_SHAPES spheres / axis-aligned cylinders.
//
// Input channel (pt_valid / pt_stall / pt): one word per point, x, y, z as
// signed 16-bit values with 4 fraction bits. A word is taken on a rising
// edge with pt_valid high and pt_stall low.
// Output channel (res_valid / res_stall / res): one word per point, in order:
// clipped, include_hit, exclude_hit.
// Config port: cfg_we writes cfg_data into register cfg_index (even index =
// shape geometry, odd index = shape mode). Write only while the pipe is empty.
//
// Four register stages: abs distance, squares, sum+compare, hit merge into
// the result register. res_valid rises when the point's word is loaded into
// the result register. Throughput is one point per cycle while res_stall is
// low; the 16x16 squaring stage sets the clock.
// pt_stall follows res_stall only once the pipe is full: empty stages take
// new words while a result waits, so bubbles are squeezed out.
// Reset clears the stage valid bits and all shape registers (every shape
// disabled, so each point comes out clipped until a shape is configured).
module point_shape_clip_test_top import psct_pkg::*; #(
	parameter int unsigned MAX_SHAPES = MAX_SHAPES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   pt_valid,
	output logic                   pt_stall,
	input  point_t                 pt,
	output logic                   res_valid,
	input  logic                   res_stall,
	output res_t                   res,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	geom_t geom[MAX_SHAPES];
	mode_t mode[MAX_SHAPES];

	logic                  valid_s1, valid_s2, valid_s3, valid_s4;
	logic                  rdy1, rdy2, rdy3, rdy4;
	adv_t                  adv;
	logic [MAX_SHAPES-1:0] inc_s3, exc_s3;
	res_t                  res_s4;
	logic                  inc_any, exc_any;

	psct_cfg #(.NSHAPES(MAX_SHAPES)) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.geom      (geom),
		.mode      (mode)
	);

	// a stage loads when it is empty or its successor loads
	assign rdy4 = !valid_s4 || !res_stall;
	assign rdy3 = !valid_s3 || rdy4;
	assign rdy2 = !valid_s2 || rdy3;
	assign rdy1 = !valid_s1 || rdy2;

	assign adv.s1 = rdy1;
	assign adv.s2 = rdy2;
	assign adv.s3 = rdy3;

	assign pt_stall = !rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= pt_valid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
			if (rdy4) valid_s4 <= valid_s3;
		end
	end

	for (genvar k = 0; k < MAX_SHAPES; k++) begin : g_shape
		psct_shape u_shape (
			.clk        (clk),
			.adv        (adv),
			.pt         (pt),
			.geom       (geom[k]),
			.mode       (mode[k]),
			.inc_hit_s3 (inc_s3[k]),
			.exc_hit_s3 (exc_s3[k])
		);
	end

	assign inc_any = |inc_s3;
	assign exc_any = |exc_s3;

	// kept only when inside an include shape and no exclude shape
	always_ff @(posedge clk) begin
		if (rdy4) begin
			res_s4.include_hit <= inc_any;
			res_s4.exclude_hit <= exc_any;
			res_s4.clipped     <= !(inc_any && !exc_any);
		end
	end

	assign res_valid = valid_s4;
	assign res       = res_s4;

endmodule

// ===== src/psct_checker.sv =====
module psct_checker import psct_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic pt_valid,
	input logic pt_stall,
	input logic res_valid,
	input logic res_stall,
	input res_t res
);

	localparam int unsigned OCC_W = $clog2(PIPE_DEPTH + 1);

	logic [OCC_W-1:0] occ_q;
	logic             in_acc, out_acc;

	assign in_acc  = pt_valid && !pt_stall;
	assign out_acc = res_valid && !res_stall;

	// words inside the pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			occ_q <= occ_q + OCC_W'(in_acc) - OCC_W'(out_acc);
		end
	end

	a_clip_rule: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.clipped == !(res.include_hit && !res.exclude_hit)))
		else $error("clipped disagrees with hit flags");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |=> (res_valid && $stable(res)))
		else $error("stalled result word changed");

	a_occ_max: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(PIPE_DEPTH))
		else $error("more words in flight than stages");

	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(occ_q < OCC_W'(PIPE_DEPTH)) |-> !pt_stall)
		else $error("input stalled with an empty stage");

	a_res_has_src: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (occ_q != '0))
		else $error("result word without an accepted point");

endmodule

bind point_shape_clip_test_top psct_checker u_psct_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.pt_valid  (pt_valid),
	.pt_stall  (pt_stall),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res       (res)
);
